// File: hdl/sle_pkg.sv
// Shared types and constants for the sprite line evaluation unit.
// No dependencies; imported by every module of the block.
package sle_pkg;

	localparam int ENTRY_COUNT_DEF  = 64;
	localparam int MAX_PER_LINE_DEF = 8;

	localparam int OAM_BYTES    = 256;
	localparam int OAM_AW       = 8;
	localparam int INDEX_W      = 6;
	localparam int LIST_SLOTS   = 8;
	localparam int COUNT_W      = 4;
	localparam int START_W      = 6;
	localparam int CFG_INDEX_W  = 2;
	localparam int CFG_DATA_W   = 6;

	typedef enum logic [1:0] {
		OP_WRITE = 2'd0,
		OP_READ  = 2'd1,
		OP_EVAL  = 2'd2
	} sle_op_t;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_TALL  = 2'd0,
		REG_START = 2'd1
	} sle_reg_t;

	typedef struct packed {
		logic [1:0] operation;
		logic [7:0] byte_addr;
		logic [7:0] write_data;
		logic [7:0] line_number;
	} sle_item_t;

	typedef struct packed {
		logic [7:0]                     read_data;
		logic [COUNT_W-1:0]             found_count;
		logic [LIST_SLOTS*INDEX_W-1:0]  found_list;
		logic                           overflow;
	} sle_result_t;

	typedef struct packed {
		logic               valid;
		logic [INDEX_W-1:0] idx;
	} sle_token_t;

endpackage

// File: hdl/sle_oam.sv
// Object attribute memory, 256 bytes, with per-byte valid bits cleared at reset.
// Depends on sle_pkg.
module sle_oam (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  we,
	input  logic [sle_pkg::OAM_AW-1:0] waddr,
	input  logic [7:0]            wdata,
	input  logic [sle_pkg::OAM_AW-1:0] raddr,
	output logic [7:0]            rdata
);
	import sle_pkg::*;

	logic [7:0]           mem [OAM_BYTES];
	logic [OAM_BYTES-1:0] valid_q;
	logic [7:0]           rdata_q;
	logic                 rvalid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= '0;
			rvalid_q <= 1'b0;
		end else begin
			if (we) begin
				valid_q[waddr] <= 1'b1;
			end
			rvalid_q <= valid_q[raddr];
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rvalid_q ? rdata_q : 8'd0;

endmodule

// File: hdl/sle_cell.sv
// One slot of the found-sprite chain: keeps the first token it sees, forwards the rest.
// Depends on sle_pkg.
module sle_cell (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                clear,
	input  sle_pkg::sle_token_t in_tok,
	output sle_pkg::sle_token_t out_tok,
	output sle_pkg::sle_token_t slot
);
	import sle_pkg::*;

	logic               full_q;
	logic [INDEX_W-1:0] idx_q;
	logic               fwd_valid_q;
	logic [INDEX_W-1:0] fwd_idx_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			full_q      <= 1'b0;
			fwd_valid_q <= 1'b0;
		end else if (clear) begin
			full_q      <= 1'b0;
			fwd_valid_q <= 1'b0;
		end else begin
			if (in_tok.valid && !full_q) begin
				full_q <= 1'b1;
			end
			fwd_valid_q <= in_tok.valid && full_q;
		end
	end

	always_ff @(posedge clk) begin
		if (in_tok.valid && !full_q) begin
			idx_q <= in_tok.idx;
		end
		fwd_idx_q <= in_tok.idx;
	end

	assign out_tok = '{valid: fwd_valid_q, idx: fwd_idx_q};
	assign slot    = '{valid: full_q, idx: idx_q};

endmodule

// File: hdl/sprite_line_evaluation_unit.sv
// Sprite line evaluation unit: attribute memory access and per-line sprite search.
// Depends on sle_pkg, sle_oam and sle_cell.
//
// Items enter on item_valid/item_ready and one result per item leaves on
// result_valid/result_ready. Registers are written on cfg_valid/cfg_ready;
// cfg_ready is always high. One item is worked on at a time.
// Path from item transfer to result_valid: a write or unused code goes from idle
// straight to the finish state, a read passes through the read state, and an
// evaluation scans entries start_entry to ENTRY_COUNT - 1 (none if past the end).
// The scan reads one top byte per cycle from the single memory read port;
// matches then walk the chain of MAX_PER_LINE slot cells, one cell a cycle,
// and the chain drains before the result is formed.
// A finished result sits in an output register; item_ready returns the cycle
// after the result is formed, even if the receiver stalls, and a second
// result waits until the register is taken.
// Reset clears the attribute memory through per-byte valid bits, the sticky
// overflow flag, both registers and all control state; no clearing pass.
module sprite_line_evaluation_unit #(
	parameter int ENTRY_COUNT  = sle_pkg::ENTRY_COUNT_DEF,
	parameter int MAX_PER_LINE = sle_pkg::MAX_PER_LINE_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            item_valid,
	output logic                            item_ready,
	input  sle_pkg::sle_item_t              item,
	output logic                            result_valid,
	input  logic                            result_ready,
	output sle_pkg::sle_result_t            result,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [sle_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [sle_pkg::CFG_DATA_W-1:0]  cfg_data
);
	import sle_pkg::*;

	localparam int CNT_BITS = $clog2(ENTRY_COUNT + 1);
	localparam int EW       = (CNT_BITS > START_W) ? CNT_BITS : START_W + 1;
	localparam int DW       = $clog2(MAX_PER_LINE + 1);
	localparam int LS       = (MAX_PER_LINE < LIST_SLOTS) ? MAX_PER_LINE : LIST_SLOTS;

	typedef enum logic [2:0] {
		S_IDLE,
		S_READ,
		S_SCAN,
		S_DRAIN,
		S_FIN
	} state_t;

	state_t             state_q;
	logic [1:0]         op_q;
	logic [7:0]         addr_q;
	logic [7:0]         line_q;
	logic               tall_q;
	logic [START_W-1:0] start_q;
	logic [EW-1:0]      entry_q;
	logic [DW-1:0]      drain_q;
	logic               overflow_q;
	logic               rvalid_s1;
	logic [INDEX_W-1:0] idx_s1;
	sle_result_t        result_q;
	logic               result_valid_q;

	logic               item_fire;
	logic               eval_start;
	logic [OAM_AW-1:0]  raddr;
	logic [7:0]         rdata;
	logic [7:0]         diff;
	logic               hit;
	logic               load;
	logic [4:0]         count5;
	logic [COUNT_W-1:0] count_sat;
	logic [LIST_SLOTS*INDEX_W-1:0] list;

	sle_token_t tok  [MAX_PER_LINE+1];
	sle_token_t slot [MAX_PER_LINE];

	assign item_ready   = (state_q == S_IDLE);
	assign item_fire    = item_valid && item_ready;
	assign eval_start   = item_fire && (item.operation == OP_EVAL);
	assign cfg_ready    = 1'b1;
	assign result_valid = result_valid_q;
	assign result       = result_q;
	assign load         = (state_q == S_FIN) && (!result_valid_q || result_ready);

	assign raddr = (state_q == S_SCAN) ? {entry_q[INDEX_W-1:0], 2'b00} : addr_q;

	sle_oam u_oam (
		.clk    (clk),
		.arst_n (arst_n),
		.we     (item_fire && (item.operation == OP_WRITE)),
		.waddr  (item.byte_addr),
		.wdata  (item.write_data),
		.raddr  (raddr),
		.rdata  (rdata)
	);

	assign diff   = line_q - rdata;
	assign hit    = (line_q >= rdata) && (diff[7:4] == 4'd0) && (tall_q || !diff[3]);
	assign tok[0] = '{valid: rvalid_s1 && hit, idx: idx_s1};

	for (genvar k = 0; k < MAX_PER_LINE; k++) begin : g_cell
		sle_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.clear   (eval_start),
			.in_tok  (tok[k]),
			.out_tok (tok[k+1]),
			.slot    (slot[k])
		);
	end

	always_comb begin
		count5 = '0;
		for (int k = 0; k < MAX_PER_LINE; k++) begin
			count5 = count5 + 5'(slot[k].valid);
		end
		count_sat = count5[4] ? 4'hF : count5[3:0];
		list = '0;
		for (int j = 0; j < LS; j++) begin
			list[INDEX_W*j +: INDEX_W] = slot[j].valid ? slot[j].idx : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			op_q           <= '0;
			addr_q         <= '0;
			line_q         <= '0;
			tall_q         <= 1'b0;
			start_q        <= '0;
			entry_q        <= '0;
			drain_q        <= '0;
			overflow_q     <= 1'b0;
			rvalid_s1      <= 1'b0;
			idx_s1         <= '0;
			result_q       <= '0;
			result_valid_q <= 1'b0;
		end else begin
			rvalid_s1 <= 1'b0;
			if (tok[MAX_PER_LINE].valid) begin
				overflow_q <= 1'b1;
			end
			if (cfg_valid) begin
				case (cfg_index)
					REG_TALL:  tall_q  <= cfg_data[0];
					REG_START: start_q <= cfg_data[START_W-1:0];
					default: ;
				endcase
			end
			if (result_valid_q && result_ready) begin
				result_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (item_fire) begin
						op_q    <= item.operation;
						addr_q  <= item.byte_addr;
						line_q  <= item.line_number;
						entry_q <= EW'(start_q);
						case (item.operation)
							OP_READ: state_q <= S_READ;
							OP_EVAL: state_q <= S_SCAN;
							default: state_q <= S_FIN;
						endcase
					end
				end
				S_READ: begin
					state_q <= S_FIN;
				end
				S_SCAN: begin
					if (entry_q < EW'(ENTRY_COUNT)) begin
						rvalid_s1 <= 1'b1;
						idx_s1    <= entry_q[INDEX_W-1:0];
						entry_q   <= entry_q + 1'b1;
					end else begin
						drain_q <= '0;
						state_q <= S_DRAIN;
					end
				end
				S_DRAIN: begin
					if (drain_q == DW'(MAX_PER_LINE)) begin
						state_q <= S_FIN;
					end else begin
						drain_q <= drain_q + 1'b1;
					end
				end
				S_FIN: begin
					if (load) begin
						result_valid_q       <= 1'b1;
						result_q.read_data   <= (op_q == OP_READ) ? rdata : 8'd0;
						result_q.found_count <= (op_q == OP_EVAL) ? count_sat : '0;
						result_q.found_list  <= (op_q == OP_EVAL) ? list : '0;
						result_q.overflow    <= overflow_q;
						state_q              <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

// File: hdl/sle_checker.sv
// Port-level checks for the sprite line evaluation unit, bound to the top level.
// Depends on sle_pkg and sprite_line_evaluation_unit.
module sle_checker (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 result_valid,
	input logic                 result_ready,
	input sle_pkg::sle_result_t result
);
	import sle_pkg::*;

	logic seen_ovf_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_ovf_q <= 1'b0;
		end else if (result_valid && result_ready && result.overflow) begin
			seen_ovf_q <= 1'b1;
		end
	end

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(result))
		else $error("result changed while stalled");

	a_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && seen_ovf_q |-> result.overflow)
		else $error("overflow flag dropped");

	a_read_no_list: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (result.read_data != 8'd0) |->
			(result.found_count == '0) && (result.found_list == '0))
		else $error("read result carries a sprite list");

	a_empty_list: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (result.found_count == '0) |-> (result.found_list == '0))
		else $error("list not empty with zero count");

endmodule

bind sprite_line_evaluation_unit sle_checker u_sle_checker (.*);
